[sv/http_message_head_tokenizer_macros.svh]
// Assertion macros for the HTTP message head tokenizer
`ifndef HTTP_MESSAGE_HEAD_TOKENIZER_MACROS_SVH
`define HTTP_MESSAGE_HEAD_TOKENIZER_MACROS_SVH
// implication checked each clock edge outside reset
`define HMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// property that holds each clock edge outside reset
`define HMT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`endif

[sv/hmt_pkg.sv]
// Package: types, constants and helpers of the HTTP message head tokenizer
`timescale 1ns / 1ps
package hmt_pkg;
    localparam int OFFSET_BITS = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = 2;

    localparam logic [3:0] TK_METHOD     = 4'd0;
    localparam logic [3:0] TK_PATH       = 4'd1;
    localparam logic [3:0] TK_QUERY      = 4'd2;
    localparam logic [3:0] TK_VERSION    = 4'd3;
    localparam logic [3:0] TK_STATUS     = 4'd4;
    localparam logic [3:0] TK_REASON     = 4'd5;
    localparam logic [3:0] TK_HDR_NAME   = 4'd6;
    localparam logic [3:0] TK_HDR_VALUE  = 4'd7;
    localparam logic [3:0] TK_END        = 4'd8;
    localparam logic [3:0] TK_ERROR      = 4'd9;
    localparam logic [3:0] TK_INCOMPLETE = 4'd10;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FIRST_CR = 3'd1;
    localparam logic [2:0] ERR_LONE_CR  = 3'd2;
    localparam logic [2:0] ERR_STATUS   = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG = 3'd4;

    localparam logic [1:0] PH_WORD1  = 2'd0;
    localparam logic [1:0] PH_WORD2  = 2'd1;
    localparam logic [1:0] PH_WORD3  = 2'd2;
    localparam logic [1:0] PH_HEADER = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef logic [OFFSET_BITS-1:0] pos_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [3:0]  mcode;
        logic [31:0] status;
        logic [2:0]  err;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   [1:0] count;
        token_t [2:0] tok;
    } bundle_t;

    localparam int TOKEN_BITS = $bits(token_t);

    function automatic logic [7:0] verb_char(input logic [2:0] v, input logic [2:0] i);
        logic [55:0] s;
        begin
            unique case (v)
                3'd0: s = {"GET", 32'd0};
                3'd1: s = {"HEAD", 24'd0};
                3'd2: s = {"POST", 24'd0};
                3'd3: s = {"PUT", 32'd0};
                3'd4: s = {"DELETE", 8'd0};
                3'd5: s = "CONNECT";
                3'd6: s = "OPTIONS";
                default: s = {"TRACE", 16'd0};
            endcase
            verb_char = s[55 - 8*i -: 8];
        end
    endfunction

    function automatic logic [3:0] verb_size(input logic [2:0] v);
        begin
            unique case (v)
                3'd0: verb_size = 4'd3;
                3'd1: verb_size = 4'd4;
                3'd2: verb_size = 4'd4;
                3'd3: verb_size = 4'd3;
                3'd4: verb_size = 4'd6;
                3'd5: verb_size = 4'd7;
                3'd6: verb_size = 4'd7;
                default: verb_size = 4'd5;
            endcase
        end
    endfunction

    function automatic logic [15:0] trunc16(input pos_t p);
        logic [31:0] w;
        begin
            w = 32'(p);
            trunc16 = w[15:0];
        end
    endfunction
endpackage

[sv/hmt_front.sv]
// Front end: per-byte parse state and token bundle generation
`timescale 1ns / 1ps
module hmt_front
    import hmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       msg_start,
    input  logic       end_of_data,
    output logic       push,
    output bundle_t    bundle
);
    localparam logic [OFFSET_BITS:0] PMAX = {1'b0, {OFFSET_BITS{1'b1}}};

    logic [1:0]         phase_reg, phase_next;
    pos_t               pos_reg, pos_next;
    pos_t               tb_reg, tb_next;
    logic [OFFSET_BITS:0] qm_reg, qm_next;
    logic [OFFSET_BITS:0] cp_reg, cp_next;
    logic [OFFSET_BITS:0] vf_reg, vf_next;
    pos_t               ve_reg, ve_next;
    logic               cr_reg, cr_next;
    logic [7:0]         mm_reg, mm_next;
    logic [3:0]         ml_reg, ml_next;
    logic [32:0]        sa_reg, sa_next;
    logic               halt_reg, halt_next;

    logic [1:0]         ph;
    pos_t               tb, ve, p;
    logic [OFFSET_BITS:0] qm, cp, vf, p1;
    logic               cr;
    logic [7:0]         mm, up;
    logic [3:0]         ml;
    logic [32:0]        sa;
    logic [35:0]        sa10;
    logic               hl;
    logic [3:0]         mcode;
    bundle_t            b;
    token_t             t;
    pos_t               vstart, vlen, crp;
    logic               isdig;

    always_comb
    begin
        ph = phase_reg; p = pos_reg; tb = tb_reg; qm = qm_reg; cp = cp_reg; vf = vf_reg;
        ve = ve_reg; cr = cr_reg; mm = mm_reg; ml = ml_reg; sa = sa_reg; hl = halt_reg;
        if (msg_start)
        begin
            ph = PH_WORD1; p = '0; tb = '0; qm = '0; cp = '0; vf = '0; ve = '0;
            cr = 1'b0; mm = 8'hff; ml = '0; sa = '0; hl = 1'b0;
        end
        phase_next = ph; pos_next = p; tb_next = tb; qm_next = qm; cp_next = cp;
        vf_next = vf; ve_next = ve; cr_next = cr; mm_next = mm; ml_next = ml;
        sa_next = sa; halt_next = hl;
        b = '0;
        t = '0;
        p1 = {1'b0, p} + 1'b1;
        crp = p - 1'b1;
        up = (data_byte >= 8'h61 && data_byte <= 8'h7a) ? data_byte - 8'd32 : data_byte;
        mcode = 4'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (mm[i] && verb_size(3'(i)) == ml)
                mcode = 4'(i + 1);
        end
        sa10 = {3'b0, sa} * 36'd10 + {28'd0, data_byte - 8'h30};
        isdig = data_byte >= 8'h30 && data_byte <= 8'h39;
        vstart = '0; vlen = '0;
        if (!hl)
        begin
            if ({1'b0, p} >= PMAX)
            begin
                t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_TOO_LONG;
                b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
            end
            else
            begin
                unique case (ph)
                    PH_WORD1:
                    begin
                        if (data_byte == CH_SPACE)
                        begin
                            t.kind = mode ? TK_VERSION : TK_METHOD;
                            t.length = trunc16(p);
                            t.mcode = mode ? 4'd0 : mcode;
                            b.tok[0] = t; b.count = 2'd1;
                            tb_next = p1[OFFSET_BITS-1:0]; qm_next = '0; sa_next = '0;
                            phase_next = PH_WORD2;
                        end
                        else if (data_byte == CH_CR || data_byte == CH_LF)
                        begin
                            t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_FIRST_CR;
                            b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                        end
                        else if (!mode)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                if (ml >= verb_size(3'(i)) || verb_char(3'(i), ml[2:0]) != up)
                                    mm_next[i] = 1'b0;
                            end
                            if (ml != 4'd15)
                                ml_next = ml + 1'b1;
                        end
                    end
                    PH_WORD2:
                    begin
                        if (data_byte == CH_SPACE)
                        begin
                            if (mode && (p == tb || sa[32]))
                            begin
                                t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_STATUS;
                                b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                            end
                            else
                            begin
                                if (mode)
                                begin
                                    t.kind = TK_STATUS; t.start = trunc16(tb);
                                    t.length = trunc16(p - tb); t.status = sa[31:0];
                                    b.tok[0] = t; b.count = 2'd1;
                                end
                                else if (qm != '0)
                                begin
                                    t.kind = TK_PATH; t.start = trunc16(tb);
                                    t.length = trunc16(OFFSET_BITS'(qm - 1'b1) - tb);
                                    b.tok[0] = t;
                                    t.kind = TK_QUERY;
                                    t.start = trunc16(qm[OFFSET_BITS-1:0]);
                                    t.length = trunc16(p - qm[OFFSET_BITS-1:0]);
                                    b.tok[1] = t; b.count = 2'd2;
                                end
                                else
                                begin
                                    t.kind = TK_PATH; t.start = trunc16(tb);
                                    t.length = trunc16(p - tb);
                                    b.tok[0] = t; b.count = 2'd1;
                                end
                                tb_next = p1[OFFSET_BITS-1:0]; cr_next = 1'b0;
                                phase_next = PH_WORD3;
                            end
                        end
                        else if (data_byte == CH_CR || data_byte == CH_LF)
                        begin
                            t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_FIRST_CR;
                            b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                        end
                        else if (mode)
                        begin
                            if (!isdig)
                                sa_next = 33'h1_0000_0000;
                            else if (!sa[32])
                                sa_next = (sa10[35:32] != 4'd0) ? 33'h1_0000_0000
                                                                : {1'b0, sa10[31:0]};
                        end
                        else if (qm == '0 && data_byte == CH_QMARK)
                            qm_next = p1;
                    end
                    PH_WORD3:
                    begin
                        if (cr)
                        begin
                            if (data_byte != CH_LF)
                            begin
                                t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_LONE_CR;
                                b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                            end
                            else
                            begin
                                t.kind = mode ? TK_REASON : TK_VERSION;
                                t.start = trunc16(tb); t.length = trunc16(crp - tb);
                                b.tok[0] = t; b.count = 2'd1;
                                tb_next = p1[OFFSET_BITS-1:0]; cp_next = '0; vf_next = '0;
                                ve_next = '0; cr_next = 1'b0; phase_next = PH_HEADER;
                            end
                        end
                        else if (data_byte == CH_CR)
                            cr_next = 1'b1;
                    end
                    default:
                    begin
                        if (cr)
                        begin
                            if (data_byte != CH_LF)
                            begin
                                t.kind = TK_ERROR; t.start = trunc16(p); t.err = ERR_LONE_CR;
                                b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                            end
                            else if (crp == tb)
                            begin
                                t.kind = TK_END; t.length = trunc16(p1[OFFSET_BITS-1:0]);
                                b.tok[0] = t; b.count = 2'd1; halt_next = 1'b1;
                            end
                            else
                            begin
                                t.kind = TK_HDR_NAME; t.start = trunc16(tb);
                                if (cp != '0)
                                begin
                                    t.length = trunc16(OFFSET_BITS'(cp - 1'b1) - tb);
                                    if (vf != '0)
                                    begin
                                        vstart = OFFSET_BITS'(vf - 1'b1);
                                        vlen = ve - vstart;
                                    end
                                    else
                                        vstart = crp;
                                end
                                else
                                begin
                                    t.length = trunc16(crp - tb);
                                    vstart = crp;
                                end
                                b.tok[0] = t;
                                t.kind = TK_HDR_VALUE; t.start = trunc16(vstart);
                                t.length = trunc16(vlen);
                                b.tok[1] = t; b.count = 2'd2;
                                tb_next = p1[OFFSET_BITS-1:0]; cp_next = '0; vf_next = '0;
                                ve_next = '0; cr_next = 1'b0;
                            end
                        end
                        else if (data_byte == CH_CR)
                            cr_next = 1'b1;
                        else if (cp == '0)
                        begin
                            if (data_byte == CH_COLON)
                                cp_next = p1;
                        end
                        else if (data_byte != CH_SPACE && data_byte != CH_TAB)
                        begin
                            if (vf == '0)
                                vf_next = p1;
                            ve_next = p1[OFFSET_BITS-1:0];
                        end
                    end
                endcase
                pos_next = p1[OFFSET_BITS-1:0];
                if (!halt_next && end_of_data)
                begin
                    t = '0;
                    t.kind = TK_INCOMPLETE; t.length = trunc16(p1[OFFSET_BITS-1:0]);
                    b.tok[b.count] = t;
                    b.count = b.count + 1'b1;
                    halt_next = 1'b1;
                end
            end
        end
        if (b.count != 2'd0)
            b.tok[b.count - 1'b1].last = 1'b1;
    end

    assign push   = in_fire && b.count != 2'd0;
    assign bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WORD1; pos_reg <= '0; tb_reg <= '0; qm_reg <= '0; cp_reg <= '0;
            vf_reg <= '0; ve_reg <= '0; cr_reg <= 1'b0; mm_reg <= 8'hff; ml_reg <= '0;
            sa_reg <= '0; halt_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; tb_reg <= tb_next;
            qm_reg <= qm_next; cp_reg <= cp_next; vf_reg <= vf_next; ve_reg <= ve_next;
            cr_reg <= cr_next; mm_reg <= mm_next; ml_reg <= ml_next; sa_reg <= sa_next;
            halt_reg <= halt_next;
        end
    end
endmodule

[sv/hmt_back.sv]
// Back end: bundle queue and token serializer onto the output stream
`timescale 1ns / 1ps
module hmt_back
    import hmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bundle_t               bundle,
    output logic                  space,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TOKEN_BITS-1:0] m_axis_tdata
);
    `include "http_message_head_tokenizer_macros.svh"

    bundle_t              q_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [QPTR_BITS:0]   cnt_reg;
    logic [1:0]           sub_reg;
    bundle_t              head;
    logic                 pop, fire;

    assign head          = q_reg[rp_reg];
    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = head.tok[sub_reg];
    assign fire          = m_axis_tvalid && m_axis_tready;
    assign pop           = fire && (sub_reg == head.count - 1'b1);
    assign space         = cnt_reg < (QPTR_BITS+1)'(QDEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; sub_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
            begin
                rp_reg  <= rp_reg + 1'b1;
                sub_reg <= '0;
            end
            else if (fire)
                sub_reg <= sub_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end

    `HMT_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= (QPTR_BITS+1)'(QDEPTH))
    `HMT_ASSERT_IMP(a_no_overflow, cnt_reg == (QPTR_BITS+1)'(QDEPTH), !push || pop)
    `HMT_ASSERT_IMP(a_sub_range, m_axis_tvalid, sub_reg < head.count)
    `HMT_ASSERT_IMP(a_last_pop, fire, m_axis_tdata[0] == pop)
endmodule

[sv/http_message_head_tokenizer.sv]
// Top level of the HTTP message head tokenizer
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one byte of the message head per word; tuser[0] is msg_start
//   (restart, byte at offset zero), tlast is end_of_data.
//   cfg_valid/cfg_ready/cfg_data write parse_mode (0 request, 1 response); write
//   only while the block is idle.
//   m_axis carries one token per word; tlast marks the last token caused by a byte.
//   A byte is parsed in the cycle it is accepted: its tokens (none to three) enter a
//   four-entry bundle queue, which registers them before the first appears on m_axis.
//   Throughput is one byte per cycle while each byte yields at most one token and
//   m_axis is ready; a byte with several tokens sends them as that many words.
//   When m_axis stalls, the queue absorbs up to four bundles and then s_axis_tready
//   drops; no token is lost or repeated.
//   Reset clears the parse state, empties the queue and sets request mode.
module http_message_head_tokenizer
    import hmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] msg_start
    input  logic        s_axis_tlast,   // end_of_data
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] token_kind, [19:4] token_start, [35:20] token_length, [39:36] method_code,
    // [71:40] status_value, [74:72] error_kind; zero filled
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_of_run
);
    logic                  mode_reg;
    logic                  push, space, in_fire;
    bundle_t               bundle;
    logic [TOKEN_BITS-1:0] tok;
    token_t                t;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = space;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    hmt_front u_front (
        .clk(clk), .rst_n(rst_n), .mode(mode_reg), .in_fire(in_fire),
        .data_byte(s_axis_tdata), .msg_start(s_axis_tuser), .end_of_data(s_axis_tlast),
        .push(push), .bundle(bundle)
    );

    hmt_back u_back (
        .clk(clk), .rst_n(rst_n), .push(push), .bundle(bundle), .space(space),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(tok)
    );

    assign t            = token_t'(tok);
    assign m_axis_tdata = {5'd0, t.err, t.status, t.mcode, t.length, t.start, t.kind};
    assign m_axis_tlast = t.last;
endmodule

[bench/http_message_head_tokenizer_tb.sv]
// Testbench for the HTTP message head tokenizer: scripted and random heads checked against a model
`timescale 1ns / 1ps
module http_message_head_tokenizer_tb;
    import hmt_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       eod;
        logic       is_cfg;
        logic       mode;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [3:0]  mcode;
        logic [31:0] status;
        logic [2:0]  err;
        logic        last;
    } tok_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;

    http_message_head_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    byte_item_t pending_bytes[$];
    tok_t       expected_tokens[$];
    int         failures;
    int         hold_off;
    bit         stim_done;

    // tokenizer state
    logic        mode_q;
    logic [1:0]  ph;
    logic [16:0] pos_q, tbeg, qmark, colon, vfirst, vend;
    logic        cr_q;
    logic [7:0]  mmatch;
    logic [3:0]  mlen;
    logic [32:0] sacc;
    logic        halt;
    int          run_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] verb_at(int v, int i);
        string s;
        case (v)
            0: s = "GET";
            1: s = "HEAD";
            2: s = "POST";
            3: s = "PUT";
            4: s = "DELETE";
            5: s = "CONNECT";
            6: s = "OPTIONS";
            default: s = "TRACE";
        endcase
        if (i < s.len()) return s[i];
        return 8'h00;
    endfunction

    function automatic int verb_len(int v);
        int sizes[8] = '{3, 4, 4, 3, 6, 7, 7, 5};
        return sizes[v];
    endfunction

    task automatic clear_state();
        ph = PH_WORD1; pos_q = 0; tbeg = 0; qmark = 0; colon = 0; vfirst = 0;
        vend = 0; cr_q = 0; mmatch = 8'hff; mlen = 0; sacc = 0; halt = 0;
    endtask

    task automatic push_token(logic [3:0] k, logic [16:0] st, logic [16:0] ln,
                              logic [3:0] mc, logic [31:0] sv, logic [2:0] e);
        tok_t t;
        t.kind = k; t.start = st[15:0]; t.length = ln[15:0];
        t.mcode = mc; t.status = sv; t.err = e; t.last = 1'b0;
        expected_tokens.push_back(t);
        run_count++;
    endtask

    task automatic push_error(logic [16:0] p, logic [2:0] e);
        push_token(TK_ERROR, p, 0, 0, 0, e);
        halt = 1;
    endtask

    function automatic logic [3:0] method_of();
        for (int i = 0; i < 8; i++)
            if (mmatch[i] && verb_len(i) == mlen) return 4'(i + 1);
        return 4'd0;
    endfunction

    task automatic new_line(logic [16:0] p);
        tbeg = p + 1; colon = 0; vfirst = 0; vend = 0; cr_q = 0;
    endtask

    task automatic predict_byte(byte_item_t it);
        logic [16:0] p, cr, vs, vl;
        logic [7:0]  b, up;
        logic [63:0] wide;
        run_count = 0;
        b = it.data;
        if (it.start) clear_state();
        if (halt) return;
        p = pos_q;
        if (p >= 17'hffff) begin
            push_error(p, ERR_TOO_LONG);
        end
        else begin
            if (ph == PH_WORD1) begin
                if (b == CH_SPACE) begin
                    if (mode_q) push_token(TK_VERSION, 0, p, 0, 0, ERR_NONE);
                    else push_token(TK_METHOD, 0, p, method_of(), 0, ERR_NONE);
                    tbeg = p + 1; qmark = 0; sacc = 0; ph = PH_WORD2;
                end
                else if (b == CH_CR || b == CH_LF) push_error(p, ERR_FIRST_CR);
                else if (!mode_q) begin
                    up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
                    for (int i = 0; i < 8; i++)
                        if (mlen >= verb_len(i) || verb_at(i, mlen) != up) mmatch[i] = 0;
                    if (mlen < 15) mlen++;
                end
            end
            else if (ph == PH_WORD2) begin
                if (b == CH_SPACE) begin
                    if (mode_q && (p == tbeg || sacc[32])) push_error(p, ERR_STATUS);
                    else begin
                        if (mode_q) push_token(TK_STATUS, tbeg, p - tbeg, 0, sacc[31:0], 0);
                        else if (qmark != 0) begin
                            push_token(TK_PATH, tbeg, qmark - 1 - tbeg, 0, 0, 0);
                            push_token(TK_QUERY, qmark, p - qmark, 0, 0, 0);
                        end
                        else push_token(TK_PATH, tbeg, p - tbeg, 0, 0, 0);
                        tbeg = p + 1; cr_q = 0; ph = PH_WORD3;
                    end
                end
                else if (b == CH_CR || b == CH_LF) push_error(p, ERR_FIRST_CR);
                else if (mode_q) begin
                    if (b >= "0" && b <= "9") begin
                        if (!sacc[32]) begin
                            wide = 64'(sacc) * 64'd10 + 64'(b - 8'h30);
                            if (wide > 64'hffffffff) sacc = 33'h100000000;
                            else sacc = wide[32:0];
                        end
                    end
                    else sacc = 33'h100000000;
                end
                else if (qmark == 0 && b == CH_QMARK) qmark = p + 1;
            end
            else if (ph == PH_WORD3) begin
                if (cr_q) begin
                    if (b != CH_LF) push_error(p, ERR_LONE_CR);
                    else begin
                        push_token(mode_q ? TK_REASON : TK_VERSION, tbeg, p - 1 - tbeg, 0, 0, 0);
                        new_line(p);
                        ph = PH_HEADER;
                    end
                end
                else if (b == CH_CR) cr_q = 1;
            end
            else begin
                if (cr_q) begin
                    if (b != CH_LF) push_error(p, ERR_LONE_CR);
                    else begin
                        cr = p - 1;
                        if (cr == tbeg) begin
                            push_token(TK_END, 0, p + 1, 0, 0, 0);
                            halt = 1;
                        end
                        else begin
                            if (colon != 0) begin
                                push_token(TK_HDR_NAME, tbeg, colon - 1 - tbeg, 0, 0, 0);
                                if (vfirst != 0) begin
                                    vs = vfirst - 1; vl = vend - vs;
                                end
                                else begin
                                    vs = cr; vl = 0;
                                end
                            end
                            else begin
                                push_token(TK_HDR_NAME, tbeg, cr - tbeg, 0, 0, 0);
                                vs = cr; vl = 0;
                            end
                            push_token(TK_HDR_VALUE, vs, vl, 0, 0, 0);
                            new_line(p);
                        end
                    end
                end
                else if (b == CH_CR) cr_q = 1;
                else if (colon == 0) begin
                    if (b == CH_COLON) colon = p + 1;
                end
                else if (b != CH_SPACE && b != CH_TAB) begin
                    if (vfirst == 0) vfirst = p + 1;
                    vend = p + 1;
                end
            end
            pos_q = (p + 1) & 17'hffff;
            if (!halt && it.eod) begin
                push_token(TK_INCOMPLETE, 0, p + 1, 0, 0, 0);
                halt = 1;
            end
        end
        if (run_count > 0) expected_tokens[$].last = 1'b1;
    endtask

    // stimulus builders
    task automatic add_byte(logic [7:0] b, logic st = 0, logic eod = 0);
        byte_item_t it;
        it.data = b; it.start = st; it.eod = eod; it.is_cfg = 0; it.mode = 0;
        pending_bytes.push_back(it);
    endtask

    task automatic add_text(string s, logic first = 1, logic eod_last = 0);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], first && i == 0, eod_last && i == s.len() - 1);
    endtask

    task automatic add_mode(logic m);
        byte_item_t it;
        it.data = 0; it.start = 0; it.eod = 0; it.is_cfg = 1; it.mode = m;
        pending_bytes.push_back(it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        static int gap = 0;
        byte_item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 0; s_axis_tdata <= 0; s_axis_tuser <= 0; s_axis_tlast <= 0;
            cfg_valid <= 0; cfg_data <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.data = s_axis_tdata; it.start = s_axis_tuser; it.eod = s_axis_tlast;
                it.is_cfg = 0; it.mode = 0;
                predict_byte(it);
            end
            if (cfg_valid && cfg_ready) mode_q = cfg_data;
            if ((s_axis_tvalid && !s_axis_tready) || (cfg_valid && !cfg_ready))
            begin
            end
            else if (gap > 0)
            begin
                gap--;
                s_axis_tvalid <= 0; cfg_valid <= 0;
            end
            else if (pending_bytes.size() == 0)
            begin
                s_axis_tvalid <= 0; cfg_valid <= 0;
            end
            else if (pending_bytes[0].is_cfg)
            begin
                s_axis_tvalid <= 0;
                if (!cfg_valid && expected_tokens.size() == 0 && !m_axis_tvalid)
                begin
                    cfg_valid <= 1;
                    cfg_data <= pending_bytes[0].mode;
                    void'(pending_bytes.pop_front());
                end
                else cfg_valid <= 0;
            end
            else
            begin
                cfg_valid <= 0;
                it = pending_bytes.pop_front();
                s_axis_tvalid <= 1; s_axis_tdata <= it.data;
                s_axis_tuser <= it.start; s_axis_tlast <= it.eod;
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (rst_n && hold_off > 0)
            hold_off--;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        static int stall = 0;
        tok_t got, want;
        if (!rst_n) m_axis_tready <= 0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tdata[3:0]; got.start = m_axis_tdata[19:4];
                got.length = m_axis_tdata[35:20]; got.mcode = m_axis_tdata[39:36];
                got.status = m_axis_tdata[71:40]; got.err = m_axis_tdata[74:72];
                got.last = m_axis_tlast;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token kind %0d", got.kind);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("token_kind exp %0d got %0d", want.kind, got.kind); failures++; end
                    if (got.start !== want.start) begin
                        $error("token_start exp %0d got %0d", want.start, got.start); failures++; end
                    if (got.length !== want.length) begin
                        $error("token_length exp %0d got %0d", want.length, got.length);
                        failures++;
                    end
                    if (got.mcode !== want.mcode) begin
                        $error("method_code exp %0d got %0d", want.mcode, got.mcode); failures++; end
                    if (got.status !== want.status) begin
                        $error("status_value exp %0d got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_kind exp %0d got %0d", want.err, got.err); failures++; end
                    if (got.last !== want.last) begin
                        $error("last_of_run exp %0d got %0d", want.last, got.last); failures++; end
                end
            end
            if (hold_off > 0)
            begin
                m_axis_tready <= 0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 0;
            end
            else
            begin
                m_axis_tready <= 1;
                stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            end
        end
    end

    initial
    begin
        failures = 0; hold_off = 0; stim_done = 0;
        mode_q = 0;
        clear_state();
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        add_text("get /a?b?c HTTP/1.1\r\nHost: x \r\n:\tv\t\r\nNoColon\r\nE:  \r\n\r\n");
        add_text("CONNECTX / H\r\n\r\n");
        add_text("\r");
        add_text("GET x\n");
        add_text("TRACE /\n HTTP\rZ\r\n\r\nqq");
        add_text("DELETE /p HT", 1, 1);
        add_mode(1);
        add_text("HTTP/1.1 4294967296 X\r\n");
        add_text("V  \r\n");
        add_text("V 2a0 R\r\n");
        add_text("V 200 \r\nH\r\r");
        add_byte(8'hff, 1, 1);
        for (int i = 0; i < 20; i++)
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 15) == 0);
        add_text("HTTP/1.0 200 OK\r\n");
        hold_off = 60;
        for (int i = 0; i < 3; i++) add_text("A:b\r\n", 0);
        add_text("\r\n", 0);

        while (pending_bytes.size() != 0 || s_axis_tvalid || cfg_valid) @(posedge clk);
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_tokens.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
